// ===== hw/rtl/mfle_pkg.sv =====
// Package for the mbox From-line escaper: character codes, sizes and the command type.
package mfle_pkg;

  localparam int unsigned WIN_DEPTH = 5;
  localparam int unsigned FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int unsigned SLOTS     = WIN_DEPTH + 2;
  localparam int unsigned CNT_W     = $clog2(SLOTS + 1);

  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_F  = 8'h46;

  // "rom " that must follow the 'F'
  localparam logic [WIN_DEPTH-2:0][7:0] TAIL_ROM = {8'h20, 8'h6D, 8'h6F, 8'h72};

  // One command from the front to the back.
  typedef struct packed {
    logic                           quote;     // emit '>' before head
    logic                           head_vld;  // emit head
    logic [7:0]                     head;
    logic [WIN_DEPTH-1:0][7:0]      win;       // flush bytes, win[0] first
    logic [FILL_W-1:0]              cnt;       // flush byte count, 0 if not last
  } cmd_t;

endpackage

// ===== hw/rtl/mfle_front.sv =====
// Front: lookahead window, line-start tracking and "From " detection.
module mfle_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output mfle_pkg::cmd_t q_cmd_o
);
  import mfle_pkg::*;

  logic [WIN_DEPTH-1:0][7:0] win_q, win_d, win_new;
  logic [FILL_W-1:0]         fill_q, fill_d, fill_new;
  logic                      als_q, als_d, als_new;
  logic                      accept, full5, tail_ok;
  cmd_t                      cmd;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign full5      = (fill_q == FILL_W'(WIN_DEPTH));
  assign tail_ok    = (win_q[WIN_DEPTH-1:1] == TAIL_ROM);

  always_comb begin
    win_new      = win_q;
    fill_new     = fill_q;
    als_new      = als_q;
    cmd          = '0;
    cmd.head     = win_q[0];
    if (full5) begin
      cmd.head_vld = 1'b1;
      if (win_q[0] == CH_LF) begin
        als_new = 1'b1;
      end else if (win_q[0] != CH_GT) begin
        cmd.quote = (win_q[0] == CH_F) && als_q && tail_ok;
        als_new   = 1'b0;
      end
      win_new = {in_byte_i, win_q[WIN_DEPTH-1:1]};
    end else begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        if (fill_q == FILL_W'(i)) begin
          win_new[i] = in_byte_i;
        end
      end
      fill_new = fill_q + 1'b1;
    end
    cmd.win = win_new;
    if (in_last_i) begin
      cmd.cnt = fill_new;
    end

    win_d  = win_q;
    fill_d = fill_q;
    als_d  = als_q;
    if (accept) begin
      if (in_last_i) begin
        win_d  = '0;
        fill_d = '0;
        als_d  = 1'b0;
      end else begin
        win_d  = win_new;
        fill_d = fill_new;
        als_d  = als_new;
      end
    end
  end

  assign q_push_o = accept && (cmd.head_vld || in_last_i);
  assign q_cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
      als_q  <= 1'b0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
      als_q  <= als_d;
    end
  end

endmodule

// ===== hw/rtl/mfle_cmd_fifo.sv =====
// Two-entry command queue between front and back.
module mfle_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mfle_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           vld_o,
  output mfle_pkg::cmd_t rdata_o
);
  import mfle_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign vld_o   = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== hw/rtl/mfle_back.sv =====
// Back: expands a command into bytes, one per cycle unless stalled.
module mfle_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_vld_i,
  input  mfle_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);
  import mfle_pkg::*;

  logic [SLOTS-1:0][7:0] sh_q, sh_d, ld;
  logic [CNT_W-1:0]      cnt_q, cnt_d, ld_cnt;
  logic                  last_q, last_d;
  logic                  taken;

  // pack the command's bytes into consecutive slots
  always_comb begin
    ld = '0;
    if (q_cmd_i.quote) begin
      ld[0] = CH_GT;
      ld[1] = q_cmd_i.head;
      for (int j = 0; j < WIN_DEPTH; j++) ld[j+2] = q_cmd_i.win[j];
    end else if (q_cmd_i.head_vld) begin
      ld[0] = q_cmd_i.head;
      for (int j = 0; j < WIN_DEPTH; j++) ld[j+1] = q_cmd_i.win[j];
    end else begin
      for (int j = 0; j < WIN_DEPTH; j++) ld[j] = q_cmd_i.win[j];
    end
    ld_cnt = CNT_W'(q_cmd_i.quote) + CNT_W'(q_cmd_i.head_vld) + CNT_W'(q_cmd_i.cnt);
  end

  assign taken   = out_valid_o && !out_stall_i;
  assign q_pop_o = q_vld_i && ((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && taken));

  always_comb begin
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    if (q_pop_o) begin
      sh_d   = ld;
      cnt_d  = ld_cnt;
      last_d = (q_cmd_i.cnt != '0);
    end else if (taken) begin
      sh_d  = {8'h00, sh_q[SLOTS-1:1]};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = sh_q[0];
  assign out_last_o  = last_q && (cnt_q == CNT_W'(1));

endmodule

// ===== hw/rtl/mbox_from_line_escaper_core.sv =====
// Top level of the mbox From-line escaper.
// Takes message bytes (in_last_i on the final one) and gives them back with a '>'
// put before each "From " whose 'F' follows a newline and only '>' characters;
// a "From " at the start of a message and anything in a message's final five bytes
// are never quoted. Each byte is held in a five-byte lookahead window, so output
// trails input by five bytes; the byte flagged last flushes the window. The front
// takes one request per cycle unless the queue is full; the back emits one output
// byte per cycle while the output is not stalled. A request releases at most two
// bytes, up to seven on a last byte. A two-entry command queue between them
// absorbs the end flush; bytes pass the queue, then the back's shift register.
module mbox_from_line_escaper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import mfle_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, full, pop, q_vld;

  mfle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  mfle_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .vld_o   (q_vld),
    .rdata_o (pop_cmd)
  );

  mfle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (q_vld),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

// ===== hw/rtl/mfle_checker.sv =====
// Port-level checks for the escaper core, bound to the top level.
module mfle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       in_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // a stalled output request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("output request changed while stalled");

  // output staying idle means the queue is not full, so input cannot be stalled
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && $past(!out_valid_o) |-> !in_stall_o)
    else $error("input stalled while output side idle");

  // a taken last byte always leads to a pending output request
  a_last_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_last_i |-> ##2 out_valid_o)
    else $error("no output after last byte");

endmodule

bind mbox_from_line_escaper_core mfle_checker u_mfle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_last_i   (in_last_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);

// ===== bench/mbox_from_line_escaper_core_test.sv =====
// Self-checking testbench for the mbox From-line escaper core.
`timescale 1ns / 100ps

module mbox_from_line_escaper_core_test;
  import mfle_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned PHASE_ITEMS  = 10;
  localparam int unsigned N_PHASES     = 5;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned N_DIR        = 5;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } out_beat_t;

  // Directed message: text is right-aligned, first byte highest; exp_len 0 means predicted.
  typedef struct {
    int unsigned len;
    logic [95:0] text;
    int unsigned exp_len;
    logic [95:0] exp;
  } dir_row_t;

  dir_row_t dir_tab [N_DIR] = '{
    '{1,  96'h00,         1,  96'h00},
    '{1,  96'hFF,         1,  96'hFF},
    '{5,  "From ",        5,  "From "},
    '{11, "\nFrom xyzab", 12, "\n>From xyzab"},
    '{7,  "From xy",      0,  96'h0}
  };

  // sender idle / receiver stall percentages per phase; the last phase adds a long hold
  int unsigned idle_tab  [N_PHASES] = '{0, 57, 0, 35, 0};
  int unsigned stall_tab [N_PHASES] = '{0, 0, 57, 35, 0};

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  bit          predict_on = 1'b1;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned hold_left  = 0;
  int unsigned errors     = 0;
  int unsigned cycles     = 0;

  // predictor state
  logic [7:0]  win [WIN_DEPTH] = '{default: 8'h00};
  int unsigned win_fill        = 0;
  bit          line_start      = 1'b0;

  out_beat_t  escaped_q [$];
  logic [7:0] msg_q [$];

  mbox_from_line_escaper_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .in_last_i   (in_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .out_last_o  (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    errors++;
  endtask

  // Shift one request through the lookahead window and work out the bytes it releases.
  task automatic escape_byte(input logic [7:0] b, input logic eom, input bit keep);
    out_beat_t  res [$];
    logic [7:0] head;
    if (win_fill >= WIN_DEPTH) begin
      head = win[0];
      if (head == CH_LF) begin
        line_start = 1'b1;
      end else if (head != CH_GT) begin
        if (head == CH_F && line_start && {win[4], win[3], win[2], win[1]} == TAIL_ROM) begin
          res.push_back(out_beat_t'{CH_GT, 1'b0});
        end
        line_start = 1'b0;
      end
      res.push_back(out_beat_t'{head, 1'b0});
      for (int i = 0; i < WIN_DEPTH - 1; i++) win[i] = win[i + 1];
      win[WIN_DEPTH - 1] = b;
    end else begin
      win[win_fill] = b;
      win_fill++;
    end
    if (eom) begin
      for (int i = 0; i < win_fill; i++) res.push_back(out_beat_t'{win[i], i + 1 == win_fill});
      win        = '{default: 8'h00};
      win_fill   = 0;
      line_start = 1'b0;
    end
    if (keep) begin
      foreach (res[i]) escaped_q.push_back(res[i]);
    end
  endtask

  // Entered and left at a falling edge; returns once the request is taken.
  task automatic send_byte(input logic [7:0] b, input logic eom, input bit keep);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_byte    = b;
    in_last    = eom;
    predict_on = keep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_msg(input bit keep);
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1, keep);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  // Mostly line structure and "From " pieces; some messages are pure noise.
  task automatic make_msg();
    int unsigned len;
    int unsigned tok;
    bit          noise;
    msg_q.delete();
    len   = ($urandom_range(7) == 0) ? $urandom_range(40, 19) : $urandom_range(18, 1);
    noise = ($urandom_range(4) == 0);
    while (msg_q.size() < len) begin
      tok = noise ? 9 : $urandom_range(9);
      case (tok)
        0, 1: msg_q.push_back(CH_LF);
        2: msg_q.push_back(CH_GT);
        3, 4: push_text("From ");
        5: msg_q.push_back(CH_F);
        6: push_text("Fro");
        default: msg_q.push_back(8'($urandom_range(255)));
      endcase
    end
    while (msg_q.size() > len) void'(msg_q.pop_back());
  endtask

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) escape_byte(in_byte, in_last, predict_on);
      if (out_valid && !out_stall) begin
        if (escaped_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %h last %b", out_byte, out_last));
        end else begin
          want = escaped_q.pop_front();
          if (out_byte !== want.data)
            flag_mismatch($sformatf("byte %h, expected %h", out_byte, want.data));
          if (out_last !== want.eom)
            flag_mismatch($sformatf("last %b, expected %b", out_last, want.eom));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout, %0d bytes still expected", escaped_q.size());
      $display("mbox_from_line_escaper_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[r]) begin
      msg_q.delete();
      for (int i = 0; i < dir_tab[r].len; i++)
        msg_q.push_back(dir_tab[r].text[8 * (dir_tab[r].len - 1 - i) +: 8]);
      for (int j = 0; j < dir_tab[r].exp_len; j++)
        escaped_q.push_back(out_beat_t'{dir_tab[r].exp[8 * (dir_tab[r].exp_len - 1 - j) +: 8],
                                        j + 1 == dir_tab[r].exp_len});
      send_msg(dir_tab[r].exp_len == 0);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      if (ph == N_PHASES - 1) begin
        // long receiver hold while requests keep coming, so the input backs up
        in_valid = 1'b0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        make_msg();
        send_msg(1'b1);
        sent += msg_q.size();
      end
    end
    in_valid = 1'b0;

    while (escaped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && escaped_q.size() == 0) begin
      $display("mbox_from_line_escaper_core_test OK");
    end else begin
      $display("mbox_from_line_escaper_core_test NOT OK");
    end
    $finish;
  end

endmodule
